FILE: rtl/gbn_pkg.sv
`default_nettype none

package gbn_pkg;

	// input item kinds, carried on s_tuser
	typedef enum logic [1:0] {
		CMD_SEND    = 2'd0,
		CMD_ACK     = 2'd1,
		CMD_TIMEOUT = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	// result events, carried on m_tuser
	localparam logic [2:0] EV_SENT    = 3'd0;
	localparam logic [2:0] EV_REFUSED = 3'd1;
	localparam logic [2:0] EV_ACKED   = 3'd2;
	localparam logic [2:0] EV_IGNORED = 3'd3;
	localparam logic [2:0] EV_RESENT  = 3'd4;

	// retransmission timer actions
	localparam logic [1:0] TMR_NONE    = 2'd0;
	localparam logic [1:0] TMR_START   = 2'd1;
	localparam logic [1:0] TMR_STOP    = 2'd2;
	localparam logic [1:0] TMR_RESTART = 2'd3;

	localparam logic [2:0] WIN_RESET   = 3'd4;
	localparam logic [2:0] MAX_RESULTS = 3'd7;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [2:0]  event_res;
		logic [2:0]  packet_seq;
		logic [63:0] packet_data;
		logic [1:0]  timer_action;
		logic [2:0]  window_base;
		logic [2:0]  next_sequence;
		logic        last;
	} result_t;

endpackage

`default_nettype wire

FILE: rtl/go_back_n_sender_window.sv
`default_nettype none

// Go-back-N sender window. Send items (s_tuser 0) store their payload at the next
// sequence number and come back as one sent or refused result; acknowledgements
// (s_tuser 1) give one taken or ignored result; both are accepted whenever the
// output register is empty or being drained. A timer expiry (s_tuser 2) resends
// every outstanding packet oldest first, at most 7 results, each one read of the
// packet memory and then one load of the output register; s_tready is low until
// the last resent result is loaded. A timeout with nothing outstanding and the
// unused kind 3 give no result. Each item's final result carries m_tlast.
// window_size (APB address 0) is clamped to 1 .. SEQ_SPACE-1 and should be
// written only while the block is idle.
module go_back_n_sender_window #(
	parameter int SEQ_SPACE    = 8,
	parameter int PAYLOAD_BITS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// stream in
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [71:0] s_tdata,  // payload[63:0], ack_number[66:64], ack_intact[67]
	input  wire logic [1:0]  s_tuser,  // cmd[1:0]
	// stream out
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [79:0] m_tdata,  // packet_seq[2:0], packet_data[66:3],
	                                   // timer_action[68:67], window_base[71:69],
	                                   // next_sequence[74:72]
	output logic      [2:0]  m_tuser,  // event_res[2:0]
	output logic             m_tlast,
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);
	import gbn_pkg::*;

	localparam int SW = $clog2(SEQ_SPACE);
	localparam int AW = (SW > 3) ? SW : 3;

	state_t state_q, state_d;

	logic [SW-1:0] base_q, next_q, idx_q;
	logic [2:0]    rem_q;
	logic [2:0]    win_q;
	logic          out_vld_q;
	result_t       res_q, res_d;
	logic          res_load;

	logic [PAYLOAD_BITS-1:0] mem [SEQ_SPACE];
	logic [PAYLOAD_BITS-1:0] rd_data_q;
	logic                    mem_we;

	cmd_t                    cmd;
	logic [PAYLOAD_BITS-1:0] payload;
	logic [2:0]              ack_number;
	logic                    ack_intact;

	logic [SW-1:0] cnt, next_inc, unit_a, unit_diff, unit_inc, ack_seq;
	logic [AW-1:0] win_eff, win_ext;
	logic          full, ack_ok, ack_in_win, out_free, acc;
	logic [2:0]    n_resend;

	assign cmd        = cmd_t'(s_tuser);
	assign payload    = s_tdata[PAYLOAD_BITS-1:0];
	assign ack_number = s_tdata[66:64];
	assign ack_intact = s_tdata[67];

	// outstanding count and next-number increment
	gbn_seq_unit #(.SEQ_SPACE(SEQ_SPACE)) u_cnt (
		.a    (next_q),
		.b    (base_q),
		.diff (cnt),
		.inc  (next_inc)
	);

	// shared by the ack check in idle and the resend walk
	assign ack_seq = SW'(AW'(ack_number));
	assign unit_a  = (state_q == ST_IDLE) ? ack_seq : idx_q;

	gbn_seq_unit #(.SEQ_SPACE(SEQ_SPACE)) u_walk (
		.a    (unit_a),
		.b    (base_q),
		.diff (unit_diff),
		.inc  (unit_inc)
	);

	assign win_ext    = AW'(win_q);
	assign win_eff    = (win_ext == '0) ? AW'(1) :
	                    ((win_ext > AW'(SEQ_SPACE - 1)) ? AW'(SEQ_SPACE - 1) : win_ext);
	assign full       = AW'(cnt) >= win_eff;
	assign ack_ok     = (AW+1)'(ack_number) < (AW+1)'(SEQ_SPACE);
	assign ack_in_win = ack_intact && ack_ok && (unit_diff < cnt);
	assign n_resend   = (cnt > 7) ? MAX_RESULTS : 3'(cnt);

	assign out_free = !out_vld_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && out_free;
	assign acc      = s_tvalid && s_tready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc && cmd == CMD_TIMEOUT && n_resend != '0) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = (rem_q == 3'd1) ? ST_IDLE : ST_READ;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// result build and memory write
	always_comb begin
		res_load = 1'b0;
		mem_we   = 1'b0;
		res_d    = '0;
		res_d.window_base   = 3'(base_q);
		res_d.next_sequence = 3'(next_q);
		res_d.last          = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					case (cmd)
						CMD_SEND: begin
							res_load = 1'b1;
							if (full) begin
								res_d.event_res = EV_REFUSED;
							end else begin
								mem_we               = 1'b1;
								res_d.event_res      = EV_SENT;
								res_d.packet_seq     = 3'(next_q);
								res_d.packet_data    = 64'(payload);
								res_d.timer_action   = (cnt == '0) ? TMR_START : TMR_NONE;
								res_d.next_sequence  = 3'(next_inc);
							end
						end
						CMD_ACK: begin
							res_load = 1'b1;
							if (ack_in_win) begin
								res_d.event_res    = EV_ACKED;
								res_d.window_base  = 3'(unit_inc);
								res_d.timer_action = (unit_inc == next_q) ? TMR_STOP : TMR_RESTART;
							end else begin
								res_d.event_res = EV_IGNORED;
							end
						end
						default: begin
							res_load = 1'b0;
						end
					endcase
				end
			end
			ST_EMIT: begin
				res_load           = out_free;
				res_d.event_res    = EV_RESENT;
				res_d.packet_seq   = 3'(idx_q);
				res_d.packet_data  = 64'(rd_data_q);
				res_d.timer_action = (rem_q == 3'd1) ? TMR_RESTART : TMR_NONE;
				res_d.last         = (rem_q == 3'd1);
			end
			default: begin
				res_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			base_q    <= '0;
			next_q    <= '0;
			idx_q     <= '0;
			rem_q     <= '0;
			win_q     <= WIN_RESET;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (psel && penable && pwrite && !paddr[2]) begin
				win_q <= pwdata[2:0];
			end
			if (mem_we) begin
				next_q <= next_inc;
			end
			if (state_q == ST_IDLE && acc && cmd == CMD_ACK && ack_in_win) begin
				base_q <= unit_inc;
			end
			if (state_q == ST_IDLE && acc && cmd == CMD_TIMEOUT) begin
				idx_q <= base_q;
				rem_q <= n_resend;
			end else if (state_q == ST_EMIT && out_free) begin
				idx_q <= unit_inc;
				rem_q <= rem_q - 3'd1;
			end
			if (res_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res_d;
		end
	end

	// packet memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[next_q] <= payload;
		end
		rd_data_q <= mem[idx_q];
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = res_q.event_res;
	assign m_tlast  = res_q.last;
	assign m_tdata  = {5'd0, res_q.next_sequence, res_q.window_base, res_q.timer_action,
	                   res_q.packet_data, res_q.packet_seq};

	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {29'd0, win_q};

	// outstanding packets never exceed what one timeout can resend
	assert property (@(posedge clk) disable iff (!arst_n) cnt <= 7)
		else $error("outstanding count above seven");

	// the resend walk always has packets left
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ || state_q == ST_EMIT) |-> rem_q != '0)
		else $error("resend walk with nothing left");

	// a timeout with outstanding packets starts the resend walk
	assert property (@(posedge clk) disable iff (!arst_n)
		(acc && cmd == CMD_TIMEOUT && cnt != '0) |=> state_q == ST_READ)
		else $error("timeout did not start resend");

	// window state holds while packets are resent
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |=> $stable(base_q) && $stable(next_q))
		else $error("window moved during resend");

endmodule

`default_nettype wire

FILE: rtl/gbn_seq_unit.sv
`default_nettype none

// modular sequence arithmetic: (a - b) mod space and (a + 1) mod space
module gbn_seq_unit #(
	parameter int SEQ_SPACE = 8
) (
	input  wire logic [$clog2(SEQ_SPACE)-1:0] a,
	input  wire logic [$clog2(SEQ_SPACE)-1:0] b,
	output logic      [$clog2(SEQ_SPACE)-1:0] diff,
	output logic      [$clog2(SEQ_SPACE)-1:0] inc
);
	localparam int SW = $clog2(SEQ_SPACE);

	logic [SW:0] wide;

	always_comb begin
		if (a >= b) begin
			wide = (SW+1)'(a) - (SW+1)'(b);
		end else begin
			wide = (SW+1)'(a) + (SW+1)'(SEQ_SPACE) - (SW+1)'(b);
		end
		diff = SW'(wide);
		inc  = (a == SW'(SEQ_SPACE - 1)) ? '0 : a + SW'(1);
	end

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
module tb_top;
	import gbn_pkg::*;

	localparam logic [2:0] REG_WINDOW = 3'd0;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;  // payload[63:0], ack_number[66:64], ack_intact[67]
	logic [1:0]  s_tuser;  // cmd[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [79:0] m_tdata;  // packet_seq[2:0], packet_data[66:3], timer_action[68:67],
	                       // window_base[71:69], next_sequence[74:72]
	logic [2:0]  m_tuser;  // event_res[2:0]
	logic        m_tlast;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// sender window as the block should see it
	logic [2:0]  wnd_cfg;
	logic [2:0]  oldest_seq;
	logic [2:0]  fresh_seq;
	logic [63:0] sent_words [8];

	result_t     awaited_results [$];
	int          errors;
	int          rx_stall;
	bit          steady;

	go_back_n_sender_window i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	initial begin
		#(8 * 400000);
		$display("TB_ERROR");
		$finish;
	end

	function automatic void push_result(logic [2:0] ev, logic [2:0] seq, logic [63:0] data,
	                                    logic [1:0] tmr, logic lst);
		result_t r;
		r.event_res     = ev;
		r.packet_seq    = seq;
		r.packet_data   = data;
		r.timer_action  = tmr;
		r.window_base   = oldest_seq;
		r.next_sequence = fresh_seq;
		r.last          = lst;
		awaited_results.push_back(r);
	endfunction

	function automatic logic [2:0] in_flight();
		return fresh_seq - oldest_seq;
	endfunction

	// advances the window for one accepted transfer and queues what it should produce
	task automatic window_step(cmd_t c, logic [63:0] pl, logic [2:0] an, logic ai);
		logic [2:0] cnt;
		logic [2:0] lim;
		logic [2:0] off;
		logic [2:0] seq;
		cnt = in_flight();
		lim = (wnd_cfg == 3'd0) ? 3'd1 : wnd_cfg;
		case (c)
			CMD_SEND: begin
				if (cnt >= lim) begin
					push_result(EV_REFUSED, 3'd0, 64'd0, TMR_NONE, 1'b1);
				end else begin
					seq = fresh_seq;
					sent_words[seq] = pl;
					fresh_seq = fresh_seq + 3'd1;
					push_result(EV_SENT, seq, pl, (cnt == 3'd0) ? TMR_START : TMR_NONE, 1'b1);
				end
			end
			CMD_ACK: begin
				off = an - oldest_seq;
				if (ai && off < cnt) begin
					oldest_seq = an + 3'd1;
					push_result(EV_ACKED, 3'd0, 64'd0,
					            (oldest_seq == fresh_seq) ? TMR_STOP : TMR_RESTART, 1'b1);
				end else begin
					push_result(EV_IGNORED, 3'd0, 64'd0, TMR_NONE, 1'b1);
				end
			end
			CMD_TIMEOUT: begin
				for (int k = 0; k < cnt; k++) begin
					seq = oldest_seq + 3'(k);
					push_result(EV_RESENT, seq, sent_words[seq],
					            (k == cnt - 1) ? TMR_RESTART : TMR_NONE, k == cnt - 1);
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk) begin : scoreboard
		result_t got;
		result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.event_res     = m_tuser;
				got.packet_seq    = m_tdata[2:0];
				got.packet_data   = m_tdata[66:3];
				got.timer_action  = m_tdata[68:67];
				got.window_base   = m_tdata[71:69];
				got.next_sequence = m_tdata[74:72];
				got.last          = m_tlast;
				if (awaited_results.size() == 0) begin
					if (errors < 10)
						$display("unexpected result transfer: ev %0d seq %0d data %h",
						         got.event_res, got.packet_seq, got.packet_data);
					errors++;
				end else begin
					want = awaited_results.pop_front();
					if (got !== want) begin
						if (errors < 10)
							$display({"result mismatch: ev %0d/%0d seq %0d/%0d data %h/%h ",
							          "tmr %0d/%0d base %0d/%0d next %0d/%0d last %0d/%0d"},
							         want.event_res, got.event_res,
							         want.packet_seq, got.packet_seq,
							         want.packet_data, got.packet_data,
							         want.timer_action, got.timer_action,
							         want.window_base, got.window_base,
							         want.next_sequence, got.next_sequence,
							         want.last, got.last);
						errors++;
					end
				end
				rx_stall = steady ? 0 : $urandom_range(0, 9);
			end
			if (s_tvalid && s_tready)
				window_step(cmd_t'(s_tuser), s_tdata[63:0], s_tdata[66:64], s_tdata[67]);
			if (psel && penable && pwrite && pready && paddr == REG_WINDOW)
				wnd_cfg = pwdata[2:0];
		end
	end

	always @(negedge clk) begin
		if (rx_stall > 0) begin
			m_tready <= 1'b0;
			rx_stall = rx_stall - 1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic send_item(cmd_t c, logic [63:0] pl, logic [2:0] an, logic ai);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= c;
		s_tdata  <= {4'b0000, ai, an, pl};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// hold off until every awaited result is back, plus room for a silent timeout
	task automatic settle();
		s_tvalid <= 1'b0;
		while (awaited_results.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_window(logic [2:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_WINDOW;
		pwdata  <= {29'd0, value};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic test_basic_flow();
		send_item(CMD_TIMEOUT, 64'd0, 3'd0, 1'b0);
		send_item(CMD_NONE, 64'd0, 3'd0, 1'b0);
		send_item(CMD_ACK, 64'd0, 3'd3, 1'b1);
		send_item(CMD_SEND, 64'hFFFF_FFFF_FFFF_FFFF, 3'd7, 1'b1);
		send_item(CMD_SEND, 64'd0, 3'd0, 1'b0);
		send_item(CMD_SEND, 64'h5A5A_5A5A_5A5A_5A5A, 3'd0, 1'b0);
		send_item(CMD_SEND, 64'hA5A5_A5A5_A5A5_A5A5, 3'd0, 1'b0);
		// window of four is full now
		send_item(CMD_SEND, 64'h0123_4567_89AB_CDEF, 3'd0, 1'b0);
		send_item(CMD_ACK, 64'd0, 3'd0, 1'b0);
		send_item(CMD_ACK, 64'd0, 3'd7, 1'b1);
		send_item(CMD_TIMEOUT, 64'd0, 3'd0, 1'b0);
		send_item(CMD_ACK, 64'd0, 3'd1, 1'b1);
		send_item(CMD_ACK, 64'd0, 3'd3, 1'b1);
		settle();
	endtask

	task automatic test_window_limits();
		// zero clamps to a window of one
		write_window(3'd0);
		send_item(CMD_SEND, 64'hDEAD_BEEF_0000_0001, 3'd0, 1'b0);
		send_item(CMD_SEND, 64'hDEAD_BEEF_0000_0002, 3'd0, 1'b0);
		send_item(CMD_ACK, 64'd0, oldest_seq, 1'b1);
		settle();
		// widest window, sequence numbers wrap, timeout gives the most results
		write_window(3'd7);
		for (int k = 0; k < 7; k++)
			send_item(CMD_SEND, {$urandom, $urandom}, 3'd0, 1'b0);
		send_item(CMD_SEND, 64'd1, 3'd0, 1'b0);
		send_item(CMD_TIMEOUT, 64'd0, 3'd0, 1'b0);
		settle();
		// shrink below what is in flight
		write_window(3'd2);
		send_item(CMD_SEND, 64'd2, 3'd0, 1'b0);
		send_item(CMD_ACK, 64'd0, oldest_seq + 3'd4, 1'b1);
		send_item(CMD_SEND, 64'd3, 3'd0, 1'b0);
		send_item(CMD_ACK, 64'd0, oldest_seq, 1'b1);
		send_item(CMD_SEND, 64'h8000_0000_0000_0000, 3'd0, 1'b0);
		send_item(CMD_ACK, 64'd0, fresh_seq - 3'd1, 1'b1);
		settle();
	endtask

	task automatic test_random_traffic();
		int         done;
		int         pick;
		logic [2:0] cnt;
		logic [2:0] an;
		logic       ai;
		for (int ph = 0; ph < 8; ph++) begin
			settle();
			if (ph == 0)
				write_window(3'd7);
			else if (ph == 1)
				write_window(3'd0);
			else
				write_window(3'($urandom_range(0, 7)));
			steady = (ph == 4);
			done = 0;
			while (done < 15) begin
				pick = $urandom_range(0, 99);
				cnt  = in_flight();
				if (pick < 50) begin
					send_item(CMD_SEND, {$urandom, $urandom}, 3'($urandom), 1'($urandom));
					done++;
				end else if (pick < 82) begin
					if (cnt != 3'd0 && $urandom_range(0, 3) != 0) begin
						an = oldest_seq + 3'($urandom_range(0, cnt - 1));
						ai = 1'b1;
					end else begin
						an = 3'($urandom);
						ai = 1'($urandom);
					end
					send_item(CMD_ACK, {$urandom, $urandom}, an, ai);
					done++;
				end else if (pick < 95) begin
					send_item(CMD_TIMEOUT, {$urandom, $urandom}, 3'($urandom), 1'($urandom));
					if (cnt != 3'd0)
						done++;
				end else begin
					send_item(CMD_NONE, {$urandom, $urandom}, 3'($urandom), 1'($urandom));
				end
			end
			steady = 1'b0;
		end
		settle();
	endtask

	initial begin
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = CMD_SEND;
		m_tready   = 1'b0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		wnd_cfg    = WIN_RESET;
		oldest_seq = 3'd0;
		fresh_seq  = 3'd0;
		errors     = 0;
		rx_stall   = 0;
		steady     = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_basic_flow();
		test_window_limits();
		test_random_traffic();

		if (awaited_results.size() != 0)
			errors++;
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
